// ===== design/hftd_pkg.sv =====
`default_nettype none

package hftd_pkg;

   localparam int OUT_SYM_W = 8;
   localparam logic [OUT_SYM_W-1:0] END_SYMBOL_RESET = 8'd7;

   typedef struct packed {
      logic code_bit;
      logic frame_start;
   } req_type;

   typedef struct packed {
      logic [OUT_SYM_W-1:0] symbol;
      logic                 last;
      logic                 error;
   } rsp_type;

   // strobes from the decode control to the tree memories
   typedef struct packed {
      logic node_wr;
      logic node_rd;
      logic stack_wr;
      logic stack_rd;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== design/hftd_tree_mem.sv =====
`default_nettype none

module hftd_tree_mem #(
   parameter int NODE_COUNT  = 512,
   parameter int STACK_DEPTH = 256,
   parameter int ENTRY_W     = 27
) (
   input  wire logic                           clock,
   input  wire hftd_pkg::mem_ctl_type          mem_ctl,
   input  wire logic [$clog2(NODE_COUNT)-1:0]  node_waddr,
   input  wire logic [ENTRY_W-1:0]             node_wdata,
   input  wire logic [$clog2(NODE_COUNT)-1:0]  node_raddr,
   output logic      [ENTRY_W-1:0]             node_rdata,
   input  wire logic [$clog2(STACK_DEPTH)-1:0] stack_waddr,
   input  wire logic [$clog2(NODE_COUNT)-1:0]  stack_wdata,
   input  wire logic [$clog2(STACK_DEPTH)-1:0] stack_raddr,
   output logic      [$clog2(NODE_COUNT)-1:0]  stack_rdata
);

   localparam int NA_W = $clog2(NODE_COUNT);

   logic [ENTRY_W-1:0] node_mem_ff  [NODE_COUNT];
   logic [NA_W-1:0]    stack_mem_ff [STACK_DEPTH];
   logic [ENTRY_W-1:0] node_rdata_ff;
   logic [NA_W-1:0]    stack_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.node_wr) begin
         node_mem_ff[node_waddr] <= node_wdata;
      end
      if (mem_ctl.node_rd) begin
         node_rdata_ff <= node_mem_ff[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.stack_wr) begin
         stack_mem_ff[stack_waddr] <= stack_wdata;
      end
      if (mem_ctl.stack_rd) begin
         stack_rdata_ff <= stack_mem_ff[stack_raddr];
      end
   end

   assign node_rdata  = node_rdata_ff;
   assign stack_rdata = stack_rdata_ff;

endmodule

`default_nettype wire

// ===== design/hftd_rsp_queue.sv =====
`default_nettype none

module hftd_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire hftd_pkg::rsp_type push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output hftd_pkg::rsp_type      rsp_data
);

   hftd_pkg::rsp_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/huffman_tree_load_and_decode_unit.sv =====
`default_nettype none

// Bit-serial Huffman decoder. A frame opens with a pre-order tree header (tag 0 = internal
// node, tag 1 = leaf followed by SYMBOL_BITS symbol bits, MSB first), then carries code bits.
// Header bits are taken without a wait, except after the last symbol bit of a leaf with a
// pending right child, when the block stops taking bits for the pending-stack read. On an
// internal node, a code bit issues the node-table read of the chosen child, and the block
// stops taking bits until that read returns, as the next bit branches on that child; on a
// leaf root, code bits need no wait. Results pass through a two-entry output queue, so the
// block keeps taking bits while a result waits for rsp_ready. Reaching the end symbol, or
// overflowing the node table or stack in the header, stops the block until frame_start.
module huffman_tree_load_and_decode_unit #(
   parameter int NODE_COUNT  = 512,
   parameter int STACK_DEPTH = 256,
   parameter int SYMBOL_BITS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire hftd_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output hftd_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hftd_pkg::OUT_SYM_W-1:0]  csr_wdata
);

   localparam int NA_W    = $clog2(NODE_COUNT);
   localparam int FN_W    = $clog2(NODE_COUNT + 1);
   localparam int SA_W    = $clog2(STACK_DEPTH);
   localparam int ST_W    = $clog2(STACK_DEPTH + 1);
   localparam int BC_W    = (SYMBOL_BITS > 1) ? $clog2(SYMBOL_BITS) : 1;
   localparam int ENTRY_W = 1 + SYMBOL_BITS + 2 * NA_W;
   localparam int SX_W    = SYMBOL_BITS + hftd_pkg::OUT_SYM_W;

   typedef enum logic [2:0] {
      ST_TAG,
      ST_SYM,
      ST_POP,
      ST_DECODE,
      ST_WALK,
      ST_DONE,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic                   leaf;
      logic [SYMBOL_BITS-1:0] sym;
      logic [NA_W-1:0]        left;
      logic [NA_W-1:0]        right;
   } node_type;

   state_type                     state_ff, state_in;
   logic [BC_W-1:0]               bit_cnt_ff, bit_cnt_in;
   logic [SYMBOL_BITS-1:0]        shift_ff, shift_in;
   logic [FN_W-1:0]               free_ff, free_in;
   logic [ST_W-1:0]               top_ff, top_in;
   logic [NA_W-1:0]               fill_ff, fill_in;
   node_type                      cur_ff, cur_in;
   node_type                      root_ff, root_in;
   logic [hftd_pkg::OUT_SYM_W-1:0] end_sym_ff;

   hftd_pkg::mem_ctl_type mem_ctl;
   logic [NA_W-1:0]       node_waddr, node_raddr;
   node_type              node_wrec;
   logic [ENTRY_W-1:0]    node_rdata;
   node_type              rd_rec;
   logic [SA_W-1:0]       stack_waddr, stack_raddr;
   logic [NA_W-1:0]       stack_wdata, stack_rdata;

   logic              rsp_push;
   hftd_pkg::rsp_type push_data;
   logic              q_full;

   logic                  req_fire;
   logic                  fs;
   logic                  code_bit;
   state_type             eff_state;
   logic [FN_W-1:0]       eff_free;
   logic [FN_W-1:0]       eff_free_p1;
   logic [ST_W-1:0]       eff_top;
   logic [NA_W-1:0]       eff_fill;
   logic [SYMBOL_BITS:0]  sym_cat;
   logic [SYMBOL_BITS-1:0] new_sym;
   logic                  sym_last;
   logic                  overflow;
   node_type              int_rec, leaf_rec;
   logic [SX_W-1:0]       end_x, cur_symx, rd_symx;
   logic                  cur_is_end, rd_is_end;
   logic [ST_W-1:0]       top_m1;

   assign csr_ready = 1'b1;
   assign req_ready = !(state_ff inside {ST_POP, ST_WALK}) && !q_full;
   assign req_fire  = req_valid && req_ready;
   assign fs        = req_data.frame_start;
   assign code_bit  = req_data.code_bit;

   // frame_start restarts the header with this very bit
   assign eff_state   = fs ? ST_TAG : state_ff;
   assign eff_free    = fs ? FN_W'(1) : free_ff;
   assign eff_top     = fs ? '0 : top_ff;
   assign eff_fill    = fs ? '0 : fill_ff;
   assign eff_free_p1 = eff_free + FN_W'(1);

   assign sym_cat  = {shift_ff, code_bit};
   assign new_sym  = sym_cat[SYMBOL_BITS-1:0];
   assign sym_last = (bit_cnt_ff == BC_W'(SYMBOL_BITS - 1));
   assign overflow = (eff_free > FN_W'(NODE_COUNT - 2)) || (eff_top >= ST_W'(STACK_DEPTH));
   assign top_m1   = top_ff - ST_W'(1);

   assign int_rec  = '{leaf: 1'b0, sym: '0, left: eff_free[NA_W-1:0],
                       right: eff_free_p1[NA_W-1:0]};
   assign leaf_rec = '{leaf: 1'b1, sym: new_sym, left: '0, right: '0};

   assign rd_rec     = node_type'(node_rdata);
   assign end_x      = {SYMBOL_BITS'(0), end_sym_ff};
   assign cur_symx   = {{hftd_pkg::OUT_SYM_W{1'b0}}, cur_ff.sym};
   assign rd_symx    = {{hftd_pkg::OUT_SYM_W{1'b0}}, rd_rec.sym};
   assign cur_is_end = (cur_symx == end_x);
   assign rd_is_end  = (rd_symx == end_x);

   always_comb begin
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      free_in     = free_ff;
      top_in      = top_ff;
      fill_in     = fill_ff;
      cur_in      = cur_ff;
      root_in     = root_ff;
      mem_ctl     = '0;
      node_waddr  = eff_fill;
      node_wrec   = int_rec;
      node_raddr  = code_bit ? cur_ff.right : cur_ff.left;
      stack_waddr = eff_top[SA_W-1:0];
      stack_wdata = eff_free_p1[NA_W-1:0];
      stack_raddr = top_m1[SA_W-1:0];
      rsp_push    = 1'b0;
      push_data   = '0;
      case (state_ff)
         ST_POP: begin
            fill_in  = stack_rdata;
            state_in = ST_TAG;
         end
         ST_WALK: begin
            if (rd_rec.leaf) begin
               rsp_push         = 1'b1;
               push_data.symbol = rd_symx[hftd_pkg::OUT_SYM_W-1:0];
               push_data.last   = rd_is_end;
               cur_in           = root_ff;
               state_in         = rd_is_end ? ST_DONE : ST_DECODE;
            end else begin
               cur_in   = rd_rec;
               state_in = ST_DECODE;
            end
         end
         default: begin
            if (req_fire) begin
               if (fs) begin
                  state_in   = ST_TAG;
                  bit_cnt_in = '0;
                  free_in    = FN_W'(1);
                  top_in     = '0;
                  fill_in    = '0;
               end
               case (eff_state)
                  ST_TAG: begin
                     if (code_bit) begin
                        state_in   = ST_SYM;
                        bit_cnt_in = '0;
                     end else if (overflow) begin
                        state_in        = ST_ERROR;
                        rsp_push        = 1'b1;
                        push_data.error = 1'b1;
                     end else begin
                        mem_ctl.node_wr  = 1'b1;
                        mem_ctl.stack_wr = 1'b1;
                        if (eff_fill == '0) begin
                           root_in = int_rec;
                        end
                        top_in  = eff_top + ST_W'(1);
                        fill_in = eff_free[NA_W-1:0];
                        free_in = eff_free + FN_W'(2);
                     end
                  end
                  ST_SYM: begin
                     shift_in   = new_sym;
                     bit_cnt_in = bit_cnt_ff + BC_W'(1);
                     if (sym_last) begin
                        bit_cnt_in      = '0;
                        mem_ctl.node_wr = 1'b1;
                        node_wrec       = leaf_rec;
                        if (fill_ff == '0) begin
                           root_in = leaf_rec;
                        end
                        if (top_ff == '0) begin
                           // header done: walk starts at the root, forward it if just written
                           state_in = ST_DECODE;
                           cur_in   = (fill_ff == '0) ? leaf_rec : root_ff;
                        end else begin
                           mem_ctl.stack_rd = 1'b1;
                           top_in           = top_m1;
                           state_in         = ST_POP;
                        end
                     end
                  end
                  ST_DECODE: begin
                     if (cur_ff.leaf) begin
                        rsp_push         = 1'b1;
                        push_data.symbol = cur_symx[hftd_pkg::OUT_SYM_W-1:0];
                        push_data.last   = cur_is_end;
                        state_in         = cur_is_end ? ST_DONE : ST_DECODE;
                     end else begin
                        mem_ctl.node_rd = 1'b1;
                        state_in        = ST_WALK;
                     end
                  end
                  default: begin
                     state_in = state_ff;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_TAG;
         bit_cnt_ff <= '0;
         shift_ff   <= '0;
         free_ff    <= FN_W'(1);
         top_ff     <= '0;
         fill_ff    <= '0;
         end_sym_ff <= hftd_pkg::END_SYMBOL_RESET;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         free_ff    <= free_in;
         top_ff     <= top_in;
         fill_ff    <= fill_in;
         if (csr_valid && csr_ready) begin
            end_sym_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      root_ff <= root_in;
   end

   hftd_tree_mem #(
      .NODE_COUNT  (NODE_COUNT),
      .STACK_DEPTH (STACK_DEPTH),
      .ENTRY_W     (ENTRY_W)
   ) u_tree_mem (
      .clock       (clock),
      .mem_ctl     (mem_ctl),
      .node_waddr  (node_waddr),
      .node_wdata  (ENTRY_W'(node_wrec)),
      .node_raddr  (node_raddr),
      .node_rdata  (node_rdata),
      .stack_waddr (stack_waddr),
      .stack_wdata (stack_wdata),
      .stack_raddr (stack_raddr),
      .stack_rdata (stack_rdata)
   );

   hftd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (rsp_push),
      .push_data  (push_data),
      .full       (q_full),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_walk_issues_read: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (state_ff == ST_DECODE) && !fs && !cur_ff.leaf) |=> (state_ff == ST_WALK))
      else $error("internal node branch did not wait for the child read");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !q_full)
      else $error("result pushed into a full output queue");

   a_counters_bounded: assert property (@(posedge clock) disable iff (reset)
      (top_ff <= ST_W'(STACK_DEPTH)) && (free_ff <= FN_W'(NODE_COUNT)))
      else $error("stack pointer or free node counter out of range");

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && push_data.error) |=> (state_ff == ST_ERROR))
      else $error("overflow result without entering the error state");

endmodule

`default_nettype wire

// ===== bench/huffman_tree_load_and_decode_unit_tb.sv =====
`default_nettype none

module huffman_tree_load_and_decode_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_COUNT  = 512;
   localparam int STACK_DEPTH = 256;
   localparam int SYMBOL_BITS = 8;
   localparam int STUCK_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 16;

   typedef enum logic [2:0] {
      HDR_TAG,
      HDR_SYMBOL,
      CODE_WALK,
      MSG_DONE,
      HDR_FAULT
   } decode_phase_type;

   typedef struct packed {
      logic                   leaf;
      logic [SYMBOL_BITS-1:0] sym;
      logic [8:0]             left;
      logic [8:0]             right;
   } tree_node_type;

   class huffman_symbol_predictor;
      tree_node_type     tree [NODE_COUNT];
      logic [8:0]        pend [STACK_DEPTH];
      decode_phase_type  phase;
      logic [2:0]        nbits;
      logic [7:0]        shift;
      logic [9:0]        free_node;
      logic [8:0]        depth;
      logic [9:0]        fill;
      logic [8:0]        walk;
      logic [7:0]        end_sym;
      hftd_pkg::rsp_type expected_symbols [$];
      int                errors;

      function new();
         restart();
         end_sym = hftd_pkg::END_SYMBOL_RESET;
         errors  = 0;
      endfunction

      function void restart();
         phase     = HDR_TAG;
         nbits     = '0;
         shift     = '0;
         free_node = 10'd1;
         depth     = '0;
         fill      = '0;
         walk      = '0;
      endfunction

      function int pending();
         return expected_symbols.size();
      endfunction

      // Returns 1 when the bit is not simply dropped by the block.
      function bit take_code_bit(hftd_pkg::req_type r);
         logic [7:0] sym;
         logic [8:0] nxt;
         bit         hit;
         bit         live;
         if (r.frame_start) begin
            restart();
         end
         live = 1'b1;
         case (phase)
            HDR_TAG: begin
               if (r.code_bit) begin
                  phase = HDR_SYMBOL;
                  nbits = '0;
                  shift = '0;
               end else if (free_node + 2 > NODE_COUNT || depth >= STACK_DEPTH
                            || fill >= NODE_COUNT) begin
                  phase = HDR_FAULT;
                  expected_symbols.push_back('{symbol: 8'h00, last: 1'b0, error: 1'b1});
               end else begin
                  tree[fill[8:0]] = '{leaf: 1'b0, sym: '0, left: free_node[8:0],
                                      right: 9'(free_node + 1)};
                  pend[depth[7:0]] = 9'(free_node + 1);
                  depth     = depth + 9'd1;
                  fill      = free_node;
                  free_node = free_node + 10'd2;
               end
            end
            HDR_SYMBOL: begin
               shift = {shift[6:0], r.code_bit};
               if (nbits != 3'(SYMBOL_BITS - 1)) begin
                  nbits = nbits + 3'd1;
               end else begin
                  tree[fill[8:0]] = '{leaf: 1'b1, sym: shift, left: '0, right: '0};
                  nbits = '0;
                  if (depth == 0) begin
                     phase = CODE_WALK;
                     walk  = '0;
                  end else begin
                     depth = depth - 9'd1;
                     fill  = {1'b0, pend[depth[7:0]]};
                     phase = HDR_TAG;
                  end
               end
            end
            CODE_WALK: begin
               if (tree[walk].leaf) begin
                  sym = tree[walk].sym;
                  hit = 1'b1;
               end else begin
                  nxt  = r.code_bit ? tree[walk].right : tree[walk].left;
                  walk = nxt;
                  hit  = tree[nxt].leaf;
                  sym  = tree[nxt].sym;
               end
               if (hit) begin
                  walk = '0;
                  if (sym == end_sym) begin
                     phase = MSG_DONE;
                     expected_symbols.push_back('{symbol: sym, last: 1'b1, error: 1'b0});
                  end else begin
                     expected_symbols.push_back('{symbol: sym, last: 1'b0, error: 1'b0});
                  end
               end
            end
            default: begin
               live = 1'b0;
            end
         endcase
         return live;
      endfunction

      function void check_symbol(hftd_pkg::rsp_type got);
         hftd_pkg::rsp_type exp;
         if (expected_symbols.size() == 0) begin
            $display("%0t: unexpected result, expected none actual symbol=%h last=%b error=%b",
                     $time, got.symbol, got.last, got.error);
            errors++;
            return;
         end
         exp = expected_symbols.pop_front();
         if (got.symbol !== exp.symbol) begin
            $display("%0t: symbol mismatch, expected %h actual %h",
                     $time, exp.symbol, got.symbol);
            errors++;
         end
         if (got.last !== exp.last) begin
            $display("%0t: last mismatch, expected %b actual %b", $time, exp.last, got.last);
            errors++;
         end
         if (got.error !== exp.error) begin
            $display("%0t: error mismatch, expected %b actual %b", $time, exp.error, got.error);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hftd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hftd_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [hftd_pkg::OUT_SYM_W-1:0] csr_wdata = '0;

   huffman_symbol_predictor sb;
   hftd_pkg::req_type stim [$];
   int      live_bits = 0;
   bit      req_burst = 1'b0;
   int      ready_hold = 0;
   int      stuck_cycles = 0;

   huffman_tree_load_and_decode_unit #(
      .NODE_COUNT (NODE_COUNT),
      .STACK_DEPTH(STACK_DEPTH),
      .SYMBOL_BITS(SYMBOL_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_bit(logic b, logic fs);
      hftd_pkg::req_type r;
      r.code_bit    = b;
      r.frame_start = fs;
      stim.push_back(r);
   endfunction

   function automatic void add_leaf(logic [7:0] sym, logic fs);
      add_bit(1'b1, fs);
      for (int i = SYMBOL_BITS - 1; i >= 0; i--) begin
         add_bit(sym[i], 1'b0);
      end
   endfunction

   function automatic logic [7:0] pick_symbol();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return 8'h00;
      if (r < 12) return 8'hFF;
      if (r < 19) return sb.end_sym;
      return 8'($urandom_range(0, 255));
   endfunction

   // Pre-order header: count open slots, split while the leaf budget allows.
   function automatic void add_tree_frame(int max_leaves, int code_len);
      int need;
      int splits;
      bit first;
      need   = 1;
      splits = max_leaves - 1;
      first  = 1'b1;
      while (need > 0) begin
         if (splits > 0 && $urandom_range(0, 2) != 0) begin
            add_bit(1'b0, first);
            splits--;
            need++;
         end else begin
            add_leaf(pick_symbol(), first);
            need--;
         end
         first = 1'b0;
      end
      repeat (code_len) add_bit(1'($urandom_range(0, 1)), 1'b0);
   endfunction

   task automatic drive_bits();
      int gap;
      foreach (stim[i]) begin
         gap = req_burst ? 0 : pick_gap();
         @(negedge clock);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_data  = stim[i];
         req_valid = 1'b1;
         do @(posedge clock); while (!req_ready);
         if (sb.take_code_bit(stim[i])) live_bits++;
      end
      stim.delete();
   endtask

   // Drain every expected result, then let in-flight walks finish.
   task automatic settle_decoder();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_end_symbol(logic [7:0] value);
      @(negedge clock);
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.end_sym = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_traffic(int target, bit with_overflow);
      int goal;
      int kind;
      int leaves;
      int cut;
      goal = live_bits + target;
      if (with_overflow) begin
         // Chain of internal nodes until the node table runs out.
         add_bit(1'b0, 1'b1);
         repeat (NODE_COUNT / 2 - 1) add_bit(1'b0, 1'b0);
         repeat (4) add_bit(1'($urandom_range(0, 1)), 1'b0);
         drive_bits();
      end
      while (live_bits < goal) begin
         kind      = $urandom_range(0, 99);
         req_burst = ($urandom_range(0, 4) == 0);
         leaves    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         if (kind < 70) begin
            add_tree_frame(leaves, $urandom_range(4, 60));
         end else if (kind < 80) begin
            add_tree_frame(1, $urandom_range(3, 20));
         end else if (kind < 90) begin
            add_tree_frame(leaves, 0);
            cut = $urandom_range(1, stim.size());
            while (stim.size() > cut) void'(stim.pop_back());
         end else begin
            add_bit(1'($urandom_range(0, 1)), 1'b1);
            repeat ($urandom_range(5, 30)) begin
               add_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 15) == 0));
            end
         end
         drive_bits();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_symbol(rsp_data);
   end

   // Alternate ready stretches with stalls of random length.
   always @(negedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
      end else begin
         rsp_ready = !rsp_ready;
         if (rsp_ready) begin
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
         end else begin
            ready_hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      logic [7:0] settings [6];
      sb = new();
      settings = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), hftd_pkg::END_SYMBOL_RESET,
                   8'($urandom_range(0, 255)), 8'h80};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Root is a leaf holding zero: each code bit yields it.
      add_leaf(8'h00, 1'b1);
      add_bit(1'b1, 1'b0);
      // Two leaves, the right one ends the message; the trailing bit is dropped.
      add_bit(1'b0, 1'b1);
      add_leaf(8'hFF, 1'b0);
      add_leaf(hftd_pkg::END_SYMBOL_RESET, 1'b0);
      add_bit(1'b0, 1'b0);
      add_bit(1'b1, 1'b0);
      add_bit(1'b0, 1'b0);
      drive_bits();
      settle_decoder();

      foreach (settings[i]) begin
         write_end_symbol(settings[i]);
         run_traffic(240, (i == 2 || i == 4));
         settle_decoder();
      end

      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/hftd_pkg.sv
design/hftd_tree_mem.sv
design/hftd_rsp_queue.sv
design/huffman_tree_load_and_decode_unit.sv
bench/huffman_tree_load_and_decode_unit_tb.sv
